/* rtl/npw_pkg.sv */
// shared constants, types and codes for the nearest point window emitter
`timescale 1ns / 1ps
`default_nettype none

package npw_pkg;

    // map and window sizing
    localparam int MAP_DEPTH  = 256;
    localparam int MAX_WINDOW = 64;
    localparam int IDX_W      = $clog2(MAP_DEPTH);
    localparam int CNT_W      = $clog2(MAP_DEPTH + 1);
    localparam int WIN_W      = 7;
    localparam int EMIT_W     = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W      = ((CNT_W > EMIT_W) ? CNT_W : EMIT_W) + 1;

    // datapath widths
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int TRIG_W  = 16;
    localparam int PIDX_W  = 8;
    localparam int SQ_W    = 2 * DIFF_W - 1;
    localparam int DIST_W  = SQ_W + 1;
    localparam int PROD_W  = TRIG_W + DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_W  = 15;

    // output queue, sized to cover the emit pipeline in flight
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 4);

    localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(5);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    // tag that rides along with each memory read through the pipeline
    typedef struct packed {
        logic             scan;
        logic [IDX_W-1:0] idx;
        logic             found;
        logic             seen;
        logic             last;
        logic             ovf;
    } t_tag;

    typedef struct packed {
        logic signed [COORD_W-1:0] local_x;
        logic signed [COORD_W-1:0] local_y;
        logic [PIDX_W-1:0]         point_index;
        logic                      found;
        logic                      start_seen;
        logic                      overflow;
        logic                      last;
    } t_result;

endpackage

`default_nettype wire

/* rtl/nearest_point_window_emitter_core.sv */
// top level: map loader, query sequencer and shared read pipeline
//
// Input channel (i_in_valid / o_in_stall) carries clear, load and query
// requests; output channel (o_out_valid / i_out_stall) carries results.
// A clear or a load never stalls the input, so loads stream one per cycle. A
// load into a full map is dropped and sets the sticky overflow flag.
// A query holds o_in_stall high while the single map read port walks all
// n stored points and the distance pipeline drains, then it walks
// min(window, n) points from the nearest one, with the window clamped to
// 1..64, one read per cycle. The input is released once the last read of
// the walk is issued. A query with no usable point gives one result with
// found low. Results pass through an 8 deep queue: when the receiver
// stalls, the walk pauses once the results queued and in flight fill the
// queue and resumes when it drains. Reset empties the map, clears the
// overflow flag and sets the window to 5; map contents are not cleared.
// The window register is written with i_cfg_we; the user must write it
// only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_window_emitter_core import npw_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_op,
    input  wire logic signed [COORD_W-1:0] i_pos_x,
    input  wire logic signed [COORD_W-1:0] i_pos_y,
    input  wire logic signed [TRIG_W-1:0]  i_cos_heading,
    input  wire logic signed [TRIG_W-1:0]  i_sin_heading,
    input  wire logic                      i_cfg_we,
    input  wire logic [WIN_W-1:0]          i_cfg_wdata,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [COORD_W-1:0]      o_local_x,
    output logic signed [COORD_W-1:0]      o_local_y,
    output logic [PIDX_W-1:0]              o_point_index,
    output logic                           o_found,
    output logic                           o_start_seen,
    output logic                           o_overflow,
    output logic                           o_last
);

    // control registers
    t_state                    r_state;
    logic [CNT_W-1:0]          r_count;
    logic                      r_ovf;
    logic [WIN_W-1:0]          r_window;
    logic [CNT_W-1:0]          r_n;
    logic [CNT_W-1:0]          r_ptr;
    logic [IDX_W-1:0]          r_eidx;
    logic [EMIT_W-1:0]         r_left;
    logic                      r_seen;
    logic                      r_found;
    logic                      r_s1_v;
    logic                      r_s2_v;

    // query pose and pipeline payload
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic signed [TRIG_W-1:0]  r_cos;
    logic signed [TRIG_W-1:0]  r_sin;
    logic                      r_q_ovf;
    t_tag                      r_s1_tag;
    t_tag                      r_s2_tag;
    logic signed [DIFF_W-1:0]  r_s2_dx;
    logic signed [DIFF_W-1:0]  r_s2_dy;
    logic signed [TRIG_W-1:0]  r_s2_cos;
    logic signed [TRIG_W-1:0]  r_s2_sin;

    t_state                    n_state;
    logic [CNT_W-1:0]          n_count;
    logic                      n_ovf;
    logic [CNT_W-1:0]          n_n;
    logic [CNT_W-1:0]          n_ptr;
    logic [IDX_W-1:0]          n_eidx;
    logic [EMIT_W-1:0]         n_left;
    logic                      n_seen;
    logic                      n_found;

    logic                      w_acc;
    logic                      w_query;
    logic                      w_mem_we;
    logic [IDX_W-1:0]          w_rd_addr;
    logic                      w_issue;
    t_tag                      w_issue_tag;
    t_point                    w_wdata;
    t_point                    w_rdata;
    logic signed [DIFF_W-1:0]  w_dx;
    logic signed [DIFF_W-1:0]  w_dy;
    logic                      w_scan_busy;
    logic                      w_have;
    logic [IDX_W-1:0]          w_best;
    logic                      w_rot_busy;
    logic                      w_push;
    t_result                   w_res;
    t_result                   w_out;
    logic [FIFO_CNT_W-1:0]     w_fifo_cnt;
    logic [FIFO_CNT_W-1:0]     w_used;
    logic [EMIT_W-1:0]         w_win;
    logic [CMP_W-1:0]          w_emit;
    logic                      w_wrap_seen;

    assign w_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // window clamped to 1..MAX_WINDOW, emit count and wrap check
    always_comb begin
        if (r_window == '0) begin
            w_win = EMIT_W'(1);
        end else if (r_window > WIN_W'(MAX_WINDOW)) begin
            w_win = EMIT_W'(MAX_WINDOW);
        end else begin
            w_win = EMIT_W'(r_window);
        end
        w_emit      = (CMP_W'(w_win) < CMP_W'(r_n)) ? CMP_W'(w_win) : CMP_W'(r_n);
        w_wrap_seen = (w_best == '0) || ((CMP_W'(w_best) + w_emit) > CMP_W'(r_n));
    end

    // queue slots already spoken for
    assign w_used = w_fifo_cnt + FIFO_CNT_W'(r_s1_v) + FIFO_CNT_W'(r_s2_v)
                  + FIFO_CNT_W'(w_rot_busy);

    // sequencer: next state, map writes and read issue
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_ptr       = r_ptr;
        n_eidx      = r_eidx;
        n_left      = r_left;
        n_seen      = r_seen;
        n_found     = r_found;
        w_query     = 1'b0;
        w_mem_we    = 1'b0;
        w_issue     = 1'b0;
        w_rd_addr   = r_eidx;
        w_issue_tag = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (t_op'(i_op))
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_LOAD: begin
                            if (r_count < CNT_W'(MAP_DEPTH)) begin
                                w_mem_we = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            w_query = 1'b1;
                            n_n     = r_count;
                            n_ptr   = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_ptr == r_n) begin
                    n_state = S_WAIT;
                end else begin
                    w_issue          = 1'b1;
                    w_rd_addr        = r_ptr[IDX_W-1:0];
                    w_issue_tag.scan = 1'b1;
                    w_issue_tag.idx  = r_ptr[IDX_W-1:0];
                    n_ptr            = r_ptr + CNT_W'(1);
                end
            end
            S_WAIT: begin
                if (!r_s1_v && !r_s2_v && !w_scan_busy) begin
                    n_state = S_EMIT;
                    if (w_have) begin
                        n_found = 1'b1;
                        n_eidx  = w_best;
                        n_left  = EMIT_W'(w_emit);
                        n_seen  = w_wrap_seen;
                    end else begin
                        n_found = 1'b0;
                        n_eidx  = '0;
                        n_left  = EMIT_W'(1);
                        n_seen  = 1'b0;
                    end
                end
            end
            S_EMIT: begin
                if (w_used < FIFO_CNT_W'(FIFO_DEPTH)) begin
                    w_issue           = 1'b1;
                    w_issue_tag.idx   = r_eidx;
                    w_issue_tag.found = r_found;
                    w_issue_tag.last  = (r_left == EMIT_W'(1));
                    w_issue_tag.seen  = (r_left == EMIT_W'(1)) && r_seen;
                    w_issue_tag.ovf   = r_q_ovf;
                    n_left            = r_left - EMIT_W'(1);
                    if ((CNT_W'(r_eidx) + CNT_W'(1)) == r_n) begin
                        n_eidx = '0;
                    end else begin
                        n_eidx = r_eidx + IDX_W'(1);
                    end
                    if (r_left == EMIT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_window <= WINDOW_RST;
            r_n      <= '0;
            r_ptr    <= '0;
            r_eidx   <= '0;
            r_left   <= '0;
            r_seen   <= 1'b0;
            r_found  <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_n     <= n_n;
            r_ptr   <= n_ptr;
            r_eidx  <= n_eidx;
            r_left  <= n_left;
            r_seen  <= n_seen;
            r_found <= n_found;
            r_s1_v  <= w_issue;
            r_s2_v  <= r_s1_v;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    // query pose capture
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_cos   <= i_cos_heading;
            r_sin   <= i_sin_heading;
            r_q_ovf <= r_ovf;
        end
    end

    // map storage
    assign w_wdata.x = i_pos_x;
    assign w_wdata.y = i_pos_y;

    npw_map_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    // offset from the vehicle, shared by search and emit
    assign w_dx = DIFF_W'($signed(w_rdata.x)) - DIFF_W'(r_px);
    assign w_dy = DIFF_W'($signed(w_rdata.y)) - DIFF_W'(r_py);

    // heading travels with the offset so a following query cannot disturb it
    always_ff @(posedge i_clk) begin
        r_s1_tag <= w_issue_tag;
        r_s2_tag <= r_s1_tag;
        r_s2_dx  <= w_dx;
        r_s2_dy  <= w_dy;
        r_s2_cos <= r_cos;
        r_s2_sin <= r_sin;
    end

    npw_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_query),
        .i_v     (r_s2_v && r_s2_tag.scan),
        .i_idx   (r_s2_tag.idx),
        .i_dx    (r_s2_dx),
        .i_dy    (r_s2_dy),
        .o_busy  (w_scan_busy),
        .o_have  (w_have),
        .o_best  (w_best)
    );

    npw_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (r_s2_v && !r_s2_tag.scan),
        .i_tag   (r_s2_tag),
        .i_dx    (r_s2_dx),
        .i_dy    (r_s2_dy),
        .i_cos   (r_s2_cos),
        .i_sin   (r_s2_sin),
        .o_busy  (w_rot_busy),
        .o_push  (w_push),
        .o_res   (w_res)
    );

    npw_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .o_count (w_fifo_cnt)
    );

    assign o_local_x     = w_out.local_x;
    assign o_local_y     = w_out.local_y;
    assign o_point_index = w_out.point_index;
    assign o_found       = w_out.found;
    assign o_start_seen  = w_out.start_seen;
    assign o_overflow    = w_out.overflow;
    assign o_last        = w_out.last;

    // a dropped load always leaves the overflow flag set
    a_ovf_on_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_op == OP_LOAD) && (r_count == CNT_W'(MAP_DEPTH))) |=> r_ovf)
        else $error("dropped load did not set overflow");

    // the emit walk stays inside the stored points
    a_emit_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && r_found) |-> (CNT_W'(r_eidx) < r_n))
        else $error("emit index beyond point count");

    // the search walk never passes the point count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= r_n))
        else $error("search pointer beyond point count");

endmodule

`default_nettype wire

/* rtl/npw_map_mem.sv */
// point map storage, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module npw_map_mem import npw_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_point           i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_point                o_rdata
);

    t_point r_mem [MAP_DEPTH];
    t_point r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/npw_scan.sv */
// nearest point search: squared distance pipeline and running minimum
`timescale 1ns / 1ps
`default_nettype none

module npw_scan import npw_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_clear,
    input  wire logic                     i_v,
    input  wire logic [IDX_W-1:0]         i_idx,
    input  wire logic signed [DIFF_W-1:0] i_dx,
    input  wire logic signed [DIFF_W-1:0] i_dy,
    output logic                          o_busy,
    output logic                          o_have,
    output logic [IDX_W-1:0]              o_best
);

    logic signed [2*DIFF_W-1:0] w_sqx;
    logic signed [2*DIFF_W-1:0] w_sqy;
    logic                       w_take;

    logic                       r_a_v;
    logic [IDX_W-1:0]           r_a_idx;
    logic [SQ_W-1:0]            r_sq_x;
    logic [SQ_W-1:0]            r_sq_y;
    logic                       r_b_v;
    logic [IDX_W-1:0]           r_b_idx;
    logic [DIST_W-1:0]          r_dist;
    logic                       r_have;
    logic [IDX_W-1:0]           r_best;
    logic [DIST_W-1:0]          r_best_d;

    // squares, never negative so the top bit is dropped
    assign w_sqx = i_dx * i_dx;
    assign w_sqy = i_dy * i_dy;

    // strict less keeps the first index on ties, zero distance is skipped
    assign w_take = r_b_v && (r_dist != '0) && (!r_have || (r_dist < r_best_d));

    // valid bits and best flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_a_v <= i_v;
            r_b_v <= r_a_v;
            if (i_clear) begin
                r_have <= 1'b0;
            end else if (w_take) begin
                r_have <= 1'b1;
            end
        end
    end

    // distance datapath and best candidate
    always_ff @(posedge i_clk) begin
        r_a_idx <= i_idx;
        r_sq_x  <= w_sqx[SQ_W-1:0];
        r_sq_y  <= w_sqy[SQ_W-1:0];
        r_b_idx <= r_a_idx;
        r_dist  <= DIST_W'(r_sq_x) + DIST_W'(r_sq_y);
        if (w_take) begin
            r_best   <= r_b_idx;
            r_best_d <= r_dist;
        end
    end

    assign o_busy = r_a_v || r_b_v;
    assign o_have = r_have;
    assign o_best = r_best;

    // a held candidate never sits at the vehicle position
    a_best_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_best_d != '0))
        else $error("best candidate has zero distance");

endmodule

`default_nettype wire

/* rtl/npw_rot.sv */
// rotation of a point offset into the vehicle frame with saturation
`timescale 1ns / 1ps
`default_nettype none

module npw_rot import npw_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_v,
    input  wire t_tag                     i_tag,
    input  wire logic signed [DIFF_W-1:0] i_dx,
    input  wire logic signed [DIFF_W-1:0] i_dy,
    input  wire logic signed [TRIG_W-1:0] i_cos,
    input  wire logic signed [TRIG_W-1:0] i_sin,
    output logic                          o_busy,
    output logic                          o_push,
    output t_result                       o_res
);

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 <<< (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [PROD_W-1:0] w_cdx;
    logic signed [PROD_W-1:0] w_sdy;
    logic signed [PROD_W-1:0] w_cdy;
    logic signed [PROD_W-1:0] w_sdx;
    logic signed [SUM_W-1:0]  w_lx;
    logic signed [SUM_W-1:0]  w_ly;

    logic                     r_v;
    t_tag                     r_tag;
    logic signed [PROD_W-1:0] r_cdx;
    logic signed [PROD_W-1:0] r_sdy;
    logic signed [PROD_W-1:0] r_cdy;
    logic signed [PROD_W-1:0] r_sdx;

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[COORD_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[COORD_W-1:0];
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    // four products, registered
    assign w_cdx = i_cos * i_dx;
    assign w_sdy = i_sin * i_dy;
    assign w_cdy = i_cos * i_dy;
    assign w_sdx = i_sin * i_dx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= i_tag;
        r_cdx <= w_cdx;
        r_sdy <= w_sdy;
        r_cdy <= w_cdy;
        r_sdx <= w_sdx;
    end

    // sums, floor shift and clamp to the coordinate range
    assign w_lx = (SUM_W'(r_cdx) + SUM_W'(r_sdy)) >>> FRAC_W;
    assign w_ly = (SUM_W'(r_cdy) - SUM_W'(r_sdx)) >>> FRAC_W;

    always_comb begin
        o_res.found       = r_tag.found;
        o_res.start_seen  = r_tag.seen;
        o_res.overflow    = r_tag.ovf;
        o_res.last        = r_tag.last;
        o_res.point_index = PIDX_W'(r_tag.idx);
        o_res.local_x     = sat(w_lx);
        o_res.local_y     = sat(w_ly);
        if (!r_tag.found) begin
            o_res.point_index = '0;
            o_res.local_x     = '0;
            o_res.local_y     = '0;
        end
    end

    assign o_busy = r_v;
    assign o_push = r_v;

endmodule

`default_nettype wire

/* rtl/npw_out_fifo.sv */
// result queue between the emit pipeline and the output channel
`timescale 1ns / 1ps
`default_nettype none

module npw_out_fifo import npw_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_result       i_data,
    input  wire logic          i_stall,
    output logic               o_valid,
    output t_result            o_data,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  w_pop;

    assign w_pop = (r_cnt != '0) && !i_stall;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + FIFO_PTR_W'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + FIFO_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - FIFO_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

    // the credit check upstream must never let a push find the queue full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> ((r_cnt < FIFO_CNT_W'(FIFO_DEPTH)) || w_pop))
        else $error("result queue overrun");

endmodule

`default_nettype wire
